// ===== hw/rtl/mts_pkg.sv =====
// shared types and constants for the max tracking stack
// no dependencies; imported by mts_cell and max_tracking_stack
package mts_pkg;

  localparam int DEPTH  = 64;
  localparam int DATA_W = 32;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int OCC_W  = 7;
  localparam int STAT_W = 2;

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  localparam logic [STAT_W-1:0] ST_OK         = 2'd0;
  localparam logic [STAT_W-1:0] ST_POP_EMPTY  = 2'd1;
  localparam logic [STAT_W-1:0] ST_PUSH_FULL  = 2'd2;

  typedef logic signed [DATA_W-1:0] word_t;

  // shift command shared by every cell of the chain
  typedef struct packed {
    logic push;
    logic pop;
  } mts_shift_t;

endpackage

// ===== hw/rtl/mts_cell.sv =====
// one stack slot: holds an entry and the maximum of it and all entries below
// depends on mts_pkg
module mts_cell import mts_pkg::*; (
  input  logic       clk,
  input  mts_shift_t shift,
  input  word_t      upper_data,
  input  word_t      upper_max,
  input  word_t      lower_data,
  input  word_t      lower_max,
  output word_t      data,
  output word_t      max
);

  word_t data_r;
  word_t max_r;

  // push moves everything one slot deeper, pop brings it one slot up
  always_ff @(posedge clk) begin
    if (shift.push) begin
      data_r <= upper_data;
      max_r  <= upper_max;
    end else if (shift.pop) begin
      data_r <= lower_data;
      max_r  <= lower_max;
    end
  end

  assign data = data_r;
  assign max  = max_r;

endmodule

// ===== hw/rtl/max_tracking_stack.sv =====
// top level of the max tracking stack: count, control and the chain of cells
// depends on mts_pkg and mts_cell
//
// usage:
// - a push or pop is issued by raising start with in_opcode and in_value;
//   it is taken at the rising edge where start is high and busy is low.
//   busy stays low, so one transaction can be issued in every cycle.
// - each transaction gives exactly one result, shown for one cycle with
//   out_valid high, the cycle right after it was taken (throughput 1
//   transaction per cycle).
// - the stack is a chain of DEPTH cells; slot 0 is the top. every cell keeps
//   its entry and the maximum over itself and the entries below, so a pop
//   exposes the new maximum from the next cell with no rescan.
// - a pop on an empty stack or a push on a full one leaves the state alone
//   and reports it in out_status.
// - out_current_max reads 0 and out_max_valid 0 while the stack is empty.
// - synchronous reset (rst_n low) empties the stack; slot contents are not
//   cleared since only slots below the count are ever read.
// - the receiver cannot stall: each result must be taken in its cycle.
module max_tracking_stack import mts_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic              in_opcode,
  input  word_t             in_value,
  output logic              out_valid,
  output word_t             out_popped_value,
  output word_t             out_current_max,
  output logic              out_max_valid,
  output logic [OCC_W-1:0]  out_occupancy,
  output logic [STAT_W-1:0] out_status
);

  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              valid_r, valid_nxt;
  word_t             popped_r, popped_nxt;
  logic [STAT_W-1:0] status_r, status_nxt;

  word_t cell_data [DEPTH];
  word_t cell_max  [DEPTH];

  logic       accept, empty, full, push_ok, pop_ok;
  word_t      new_max;
  mts_shift_t shift;

  assign busy   = 1'b0;
  assign accept = start & ~busy;
  assign empty  = (count_r == '0);
  assign full   = (count_r == CNT_W'(DEPTH));
  assign push_ok = accept & (in_opcode == OP_PUSH) & ~full;
  assign pop_ok  = accept & (in_opcode == OP_POP) & ~empty;

  assign shift.push = push_ok;
  assign shift.pop  = pop_ok;

  // max seen by the new top entry
  assign new_max = (empty || (in_value > cell_max[0])) ? in_value : cell_max[0];

  genvar g;
  generate
    for (g = 0; g < DEPTH; g++) begin : g_cell
      word_t up_d, up_m, lo_d, lo_m;
      if (g == 0) begin : g_top
        assign up_d = in_value;
        assign up_m = new_max;
      end else begin : g_mid
        assign up_d = cell_data[g-1];
        assign up_m = cell_max[g-1];
      end
      // bottom slot keeps its own contents on a pop
      if (g == DEPTH - 1) begin : g_bot
        assign lo_d = cell_data[g];
        assign lo_m = cell_max[g];
      end else begin : g_inner
        assign lo_d = cell_data[g+1];
        assign lo_m = cell_max[g+1];
      end
      mts_cell u_cell (
        .clk        (clk),
        .shift      (shift),
        .upper_data (up_d),
        .upper_max  (up_m),
        .lower_data (lo_d),
        .lower_max  (lo_m),
        .data       (cell_data[g]),
        .max        (cell_max[g])
      );
    end
  endgenerate

  always_comb begin
    count_nxt  = count_r;
    valid_nxt  = accept;
    popped_nxt = '0;
    status_nxt = ST_OK;
    if (accept) begin
      if (in_opcode == OP_PUSH) begin
        if (full) begin
          status_nxt = ST_PUSH_FULL;
        end else begin
          count_nxt = count_r + CNT_W'(1);
        end
      end else begin
        if (empty) begin
          status_nxt = ST_POP_EMPTY;
        end else begin
          count_nxt  = count_r - CNT_W'(1);
          popped_nxt = cell_data[0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    popped_r <= popped_nxt;
    status_r <= status_nxt;
  end

  // count and top slot already reflect the transaction being reported
  assign out_valid        = valid_r;
  assign out_popped_value = popped_r;
  assign out_max_valid    = (count_r != '0);
  assign out_current_max  = (count_r != '0) ? cell_max[0] : '0;
  assign out_occupancy    = OCC_W'(count_r);
  assign out_status       = status_r;

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid)
    else $error("transaction gave no result");

  a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
    push_ok |=> count_r == $past(count_r) + CNT_W'(1))
    else $error("push did not grow the stack");

  a_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_POP_EMPTY) |-> count_r == '0)
    else $error("pop-empty status with entries held");

  a_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_PUSH_FULL) |-> count_r == CNT_W'(DEPTH))
    else $error("push-full status on a stack with room");

  a_pop_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pop_ok |=> out_popped_value <= $past(cell_max[0]))
    else $error("popped value above the tracked maximum");

endmodule

// ===== verif/tb.sv =====
// self-checking testbench for the max tracking stack: push/pop traffic with a
// running prediction of popped value, maximum, depth and status
// depends on mts_pkg and max_tracking_stack
module tb;
  import mts_pkg::*;

  localparam int    IDLE_LIMIT = 1000;
  localparam int    DRAIN_WAIT = 5;
  localparam int    NUM_ITEMS  = 1150;
  localparam word_t W_MIN      = {1'b1, {(DATA_W-1){1'b0}}};
  localparam word_t W_MAX      = {1'b0, {(DATA_W-1){1'b1}}};

  typedef struct {
    logic        op;
    word_t       value;
    int unsigned gap;   // idle cycles before this transaction
    bit          hold;  // wait for all results before issuing
  } stack_op_t;

  typedef struct {
    word_t             popped;
    word_t             cur_max;
    logic              max_ok;
    logic [OCC_W-1:0]  occ;
    logic [STAT_W-1:0] status;
  } stack_result_t;

  logic              clk;
  logic              rst_n     = 1'b0;
  logic              start     = 1'b0;
  logic              in_opcode = OP_PUSH;
  word_t             in_value  = '0;
  logic              busy;
  logic              out_valid;
  word_t             out_popped_value;
  word_t             out_current_max;
  logic              out_max_valid;
  logic [OCC_W-1:0]  out_occupancy;
  logic [STAT_W-1:0] out_status;

  stack_op_t     pending_ops[$];
  stack_result_t expected_results[$];

  // shadow of the stack contents
  word_t sp_entries[DEPTH];
  int    sp_count  = 0;
  word_t sp_max    = '0;
  bit    sp_max_ok = 1'b0;

  int          n_predicted = 0;
  int          n_checked   = 0;
  int          failures    = 0;
  int unsigned gap_count   = 0;
  int          idle_cycles = 0;

  max_tracking_stack dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_opcode        (in_opcode),
    .in_value         (in_value),
    .out_valid        (out_valid),
    .out_popped_value (out_popped_value),
    .out_current_max  (out_current_max),
    .out_max_valid    (out_max_valid),
    .out_occupancy    (out_occupancy),
    .out_status       (out_status)
  );

  function automatic stack_result_t step_stack(logic op, word_t value);
    stack_result_t r;
    r.popped  = '0;
    r.cur_max = '0;
    r.max_ok  = 1'b0;
    r.status  = ST_OK;
    if (op == OP_PUSH) begin
      if (sp_count >= DEPTH) begin
        r.status = ST_PUSH_FULL;
      end else begin
        sp_entries[sp_count] = value;
        sp_count++;
        if (!sp_max_ok || value > sp_max) begin
          sp_max    = value;
          sp_max_ok = 1'b1;
        end
      end
    end else begin
      if (sp_count == 0) begin
        r.status = ST_POP_EMPTY;
      end else begin
        sp_count--;
        r.popped = sp_entries[sp_count];
        // removing the maximum forces a search over what is left
        if (sp_count == 0 || r.popped == sp_max) begin
          sp_max_ok = (sp_count != 0);
          sp_max    = '0;
          for (int i = 0; i < sp_count; i++) begin
            if (i == 0 || sp_entries[i] > sp_max) sp_max = sp_entries[i];
          end
        end
      end
    end
    r.cur_max = sp_max_ok ? sp_max : '0;
    r.max_ok  = sp_max_ok;
    r.occ     = OCC_W'(sp_count);
    return r;
  endfunction

  function automatic word_t draw_value(int unsigned style);
    int k;
    case (style)
      0: begin
        k = $urandom_range(0, 8);
        return word_t'(k - 4);
      end
      1: begin
        case ($urandom_range(0, 3))
          0:       return W_MIN;
          1:       return W_MAX;
          2:       return '0;
          default: return '1;
        endcase
      end
      default: return word_t'($urandom);
    endcase
  endfunction

  task automatic add_op(logic op, word_t value, int unsigned gap, bit hold);
    stack_op_t t;
    t.op    = op;
    t.value = value;
    t.gap   = gap;
    t.hold  = hold;
    pending_ops.push_back(t);
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      start     <= 1'b0;
      gap_count <= 0;
    end else begin
      if (start && !busy) begin
        expected_results.push_back(step_stack(in_opcode, in_value));
        n_predicted++;
      end
      if (!(start && busy)) begin
        if (pending_ops.size() == 0) begin
          start <= 1'b0;
        end else if (gap_count < pending_ops[0].gap) begin
          gap_count <= gap_count + 1;
          start     <= 1'b0;
        end else if (pending_ops[0].hold &&
                     (n_predicted != n_checked + (out_valid ? 1 : 0) ||
                      (start && !busy))) begin
          start <= 1'b0;
        end else begin
          start     <= 1'b1;
          in_opcode <= pending_ops[0].op;
          in_value  <= pending_ops[0].value;
          gap_count <= 0;
          void'(pending_ops.pop_front());
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    stack_result_t e;
    if (rst_n && out_valid) begin
      if (expected_results.size() == 0) begin
        $error("unexpected transaction on the result port");
        failures++;
      end else begin
        e = expected_results.pop_front();
        n_checked <= n_checked + 1;
        if (out_popped_value !== e.popped) begin
          $error("popped_value: expected %0d, got %0d", e.popped, out_popped_value);
          failures++;
        end
        if (out_current_max !== e.cur_max) begin
          $error("current_max: expected %0d, got %0d", e.cur_max, out_current_max);
          failures++;
        end
        if (out_max_valid !== e.max_ok) begin
          $error("max_valid: expected %0b, got %0b", e.max_ok, out_max_valid);
          failures++;
        end
        if (out_occupancy !== e.occ) begin
          $error("occupancy: expected %0d, got %0d", e.occ, out_occupancy);
          failures++;
        end
        if (out_status !== e.status) begin
          $error("status: expected %0d, got %0d", e.status, out_status);
          failures++;
        end
      end
    end
  end

  // watchdog on cycles with no transaction on either side
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int unsigned burst_len;
    int unsigned push_pct;
    int unsigned vstyle;
    bit          no_idle;
    bit          first;

    // directed: empty pop, negative first push, duplicate maxima, drain to empty
    add_op(OP_POP,  '0,                0, 1'b0);
    add_op(OP_PUSH, W_MIN,             0, 1'b0);
    add_op(OP_PUSH, '1,                1, 1'b0);
    add_op(OP_PUSH, W_MAX,             0, 1'b0);
    add_op(OP_PUSH, '0,                2, 1'b0);
    add_op(OP_PUSH, W_MAX,             0, 1'b0);
    add_op(OP_POP,  32'sh5555_5555,    0, 1'b0);
    add_op(OP_POP,  '1,                3, 1'b0);
    add_op(OP_POP,  '0,                0, 1'b1);
    add_op(OP_POP,  '0,                0, 1'b0);
    add_op(OP_POP,  '0,                0, 1'b0);
    add_op(OP_POP,  '0,                1, 1'b0);
    add_op(OP_PUSH, 32'sh5555_5555,    0, 1'b0);
    add_op(OP_PUSH, word_t'(32'hAAAA_AAAA), 0, 1'b0);
    add_op(OP_PUSH, 32'sh5555_5555,    0, 1'b0);
    add_op(OP_POP,  '0,                0, 1'b0);
    add_op(OP_POP,  '0,                0, 1'b0);
    add_op(OP_POP,  '0,                0, 1'b0);
    add_op(OP_POP,  '0,                0, 1'b0);

    // random bursts: push-heavy ones run into full, pop-heavy ones into empty
    while (pending_ops.size() < NUM_ITEMS) begin
      burst_len = $urandom_range(10, 90);
      case ($urandom_range(0, 2))
        0:       push_pct = 85;
        1:       push_pct = 15;
        default: push_pct = 50;
      endcase
      vstyle  = $urandom_range(0, 3);
      no_idle = ($urandom_range(0, 2) == 0);
      first   = ($urandom_range(0, 4) == 0);
      repeat (burst_len) begin
        add_op(($urandom_range(1, 100) <= push_pct) ? OP_PUSH : OP_POP,
               draw_value(vstyle), no_idle ? 0 : $urandom_range(0, 3), first);
        first = 1'b0;
      end
    end

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_ops.size() != 0 || start || n_predicted != n_checked)
      @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);

    if (failures == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
